[rtl/core/kot_pkg.sv]
// Package with shared types, constants and helper functions for the keyword/operator tokenizer.
`timescale 1ns / 1ps

package kot_pkg;

    // Fixed field widths of the token beat.
    localparam int TOKEN_START_W = 16;
    localparam int LEN_W         = 8;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_TOKEN_LEN = 128;
    localparam int DEF_POSITION_BITS = 16;

    // Depth of the token queue; the byte side needs room for two tokens.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Keyword table.
    localparam int NUM_KW   = 7;
    localparam int KW_SLOTS = 8;
    localparam logic [NUM_KW-1:0] KW_ALL = '1;

    // Scan mode of the open token.
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_IDENT = 2'd1,
        MODE_INT   = 2'd2,
        MODE_OPER  = 2'd3
    } mode_t;

    // Token kinds as they appear on the output.
    typedef enum logic [3:0] {
        KIND_IDENT   = 4'd0,
        KIND_KEYWORD = 4'd1,
        KIND_INT     = 4'd2,
        KIND_BINOP   = 4'd3,
        KIND_EOL     = 4'd4,
        KIND_LBRACE  = 4'd5,
        KIND_RBRACE  = 4'd6,
        KIND_LPAREN  = 4'd7,
        KIND_RPAREN  = 4'd8,
        KIND_ERROR   = 4'd9
    } kind_t;

    // Operator character codes, packed two to a word while a run arrives.
    typedef enum logic [2:0] {
        OPC_NONE  = 3'd0,
        OPC_EQ    = 3'd1,
        OPC_GT    = 3'd2,
        OPC_LT    = 3'd3,
        OPC_MINUS = 3'd4,
        OPC_PLUS  = 3'd5,
        OPC_STAR  = 3'd6,
        OPC_SLASH = 3'd7
    } opc_t;

    // Operator codes on the output: = == - + * / > < >= <=.
    typedef enum logic [3:0] {
        OP_ASSIGN = 4'd0,
        OP_EQ     = 4'd1,
        OP_SUB    = 4'd2,
        OP_ADD    = 4'd3,
        OP_MUL    = 4'd4,
        OP_DIV    = 4'd5,
        OP_GT     = 4'd6,
        OP_LT     = 4'd7,
        OP_GE     = 4'd8,
        OP_LE     = 4'd9
    } op_code_t;

    // Keyword spellings, zero padded: MODULE FIELD DEFAULT MACRO IF ELIF ELSE.
    localparam logic [7:0] KW_CHARS [NUM_KW][KW_SLOTS] = '{
        '{8'h4D, 8'h4F, 8'h44, 8'h55, 8'h4C, 8'h45, 8'h00, 8'h00},
        '{8'h46, 8'h49, 8'h45, 8'h4C, 8'h44, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h45, 8'h46, 8'h41, 8'h55, 8'h4C, 8'h54, 8'h00},
        '{8'h4D, 8'h41, 8'h43, 8'h52, 8'h4F, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h45, 8'h4C, 8'h49, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h45, 8'h4C, 8'h53, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
        8'd6, 8'd5, 8'd7, 8'd5, 8'd2, 8'd4, 8'd4
    };

    // Classification of a closing token.
    typedef struct packed {
        kind_t      kind;
        logic [2:0] kw;
        op_code_t   op;
    } tok_class_t;

    // One token beat as it waits in the queue.
    typedef struct packed {
        kind_t                    kind;
        logic [2:0]               kw;
        op_code_t                 op;
        logic [TOKEN_START_W-1:0] start;
        logic [LEN_W-1:0]         len;
        logic                     ovf;
        logic                     last;
    } tok_beat_t;

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // Space or tab.
    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'h20, 8'h09};
    endfunction

    function automatic opc_t op_char(input logic [7:0] c);
        case (c)
            8'h3D:   return OPC_EQ;
            8'h3E:   return OPC_GT;
            8'h3C:   return OPC_LT;
            8'h2D:   return OPC_MINUS;
            8'h2B:   return OPC_PLUS;
            8'h2A:   return OPC_STAR;
            8'h2F:   return OPC_SLASH;
            default: return OPC_NONE;
        endcase
    endfunction

    // Kind of a byte that stands as a token by itself; anything unknown is an error.
    function automatic kind_t single_kind(input logic [7:0] c);
        case (c)
            8'h0A:   return KIND_EOL;
            8'h7B:   return KIND_LBRACE;
            8'h7D:   return KIND_RBRACE;
            8'h28:   return KIND_LPAREN;
            8'h29:   return KIND_RPAREN;
            default: return KIND_ERROR;
        endcase
    endfunction

    // Drop keywords whose character at position idx is not c.
    function automatic logic [NUM_KW-1:0] kw_filter(input logic [NUM_KW-1:0] cand,
                                                   input logic [LEN_W-1:0]  idx,
                                                   input logic [7:0]        c);
        logic [NUM_KW-1:0] keep;
        keep = cand;
        for (int k = 0; k < NUM_KW; k++) begin
            if (idx >= KW_LEN[k]) begin
                keep[k] = 1'b0;
            end
            else if (KW_CHARS[k][idx[2:0]] != c) begin
                keep[k] = 1'b0;
            end
        end
        return keep;
    endfunction

    // Operator code for a one-character run.
    function automatic op_code_t single_op(input opc_t a);
        case (a)
            OPC_GT:    return OP_GT;
            OPC_LT:    return OP_LT;
            OPC_MINUS: return OP_SUB;
            OPC_PLUS:  return OP_ADD;
            OPC_STAR:  return OP_MUL;
            OPC_SLASH: return OP_DIV;
            default:   return OP_ASSIGN;
        endcase
    endfunction

    // Kind, keyword index and operator code of an open token as it closes.
    function automatic tok_class_t classify(input mode_t             mode,
                                            input logic [LEN_W-1:0]  len,
                                            input logic [NUM_KW-1:0] cand,
                                            input logic [5:0]        ops,
                                            input logic              ovf);
        tok_class_t r;
        opc_t       a;
        opc_t       b;
        r = '{kind: KIND_IDENT, kw: 3'd0, op: OP_ASSIGN};
        a = opc_t'(ops[2:0]);
        b = opc_t'(ops[5:3]);
        case (mode)
            MODE_IDENT:
            begin
                // Lowest-numbered keyword wins.
                for (int k = NUM_KW - 1; k >= 0; k--) begin
                    if (!ovf && cand[k] && KW_LEN[k] == len) begin
                        r.kind = KIND_KEYWORD;
                        r.kw   = 3'(k);
                    end
                end
            end
            MODE_INT:
            begin
                r.kind = KIND_INT;
            end
            MODE_OPER:
            begin
                r.kind = KIND_ERROR;
                if (len == LEN_W'(1) && !ovf) begin
                    r.kind = KIND_BINOP;
                    r.op   = single_op(a);
                end
                else if (len == LEN_W'(2) && !ovf && b == OPC_EQ) begin
                    case (a)
                        OPC_EQ:
                        begin
                            r.kind = KIND_BINOP;
                            r.op   = OP_EQ;
                        end
                        OPC_GT:
                        begin
                            r.kind = KIND_BINOP;
                            r.op   = OP_GE;
                        end
                        OPC_LT:
                        begin
                            r.kind = KIND_BINOP;
                            r.op   = OP_LE;
                        end
                        default:
                        begin
                            r.kind = KIND_ERROR;
                        end
                    endcase
                end
            end
            default:
            begin
                r.kind = KIND_IDENT;
            end
        endcase
        return r;
    endfunction

endpackage

[rtl/core/keyword_operator_tokenizer.sv]
// Top level of the byte-serial keyword/operator tokenizer with its token queue.
`timescale 1ns / 1ps

// The tokenizer takes one source byte per clock on the byte channel while byte_ready is high
// and emits one token per clock on the token channel while token_ready is high. Each byte is
// handled in the cycle it is accepted: the open-token state is updated and the tokens it closes
// are written into a four-entry token queue, from which they are presented in order. A byte can
// produce up to two tokens (the token it closes plus a single-character token, or plus the token
// flushed at end of source); the queue drains one token per cycle while token_ready is high,
// and byte_ready stays high as long as the queue has two free entries. A byte with end_of_source
// set flushes any open token and restarts offsets at zero for the next source.
module keyword_operator_tokenizer
    import kot_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN,
    parameter int POSITION_BITS = DEF_POSITION_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     byte_valid,
    output logic                     byte_ready,
    input  logic [7:0]               char_code,
    input  logic                     end_of_source,

    output logic                     token_valid,
    input  logic                     token_ready,
    output logic [3:0]               token_kind,
    output logic [2:0]               keyword_index,
    output logic [3:0]               operator_code,
    output logic [TOKEN_START_W-1:0] token_start,
    output logic [LEN_W-1:0]         token_length,
    output logic                     length_overflow,
    output logic                     last_of_run
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN_LEN);

    // Open-token state.
    mode_t                    mode_reg,      mode_next;
    logic [LEN_W-1:0]         open_len_reg,  open_len_next;
    logic [NUM_KW-1:0]        cand_reg,      cand_next;
    logic [5:0]               ops_reg,       ops_next;
    logic [POSITION_BITS-1:0] pos_reg,       pos_next;
    logic [POSITION_BITS-1:0] start_reg,     start_next;
    logic                     ovf_reg,       ovf_next;

    // Token queue.
    tok_beat_t                queue_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   head_reg,      head_next;
    logic [QUEUE_PTR_W-1:0]   tail_reg,      tail_next;
    logic [QUEUE_PTR_W:0]     count_reg,     count_next;

    // Per-byte combinational signals.
    logic                     accept;
    logic                     pop;
    logic                     extend;
    opc_t                     opc;
    mode_t                    post_mode;
    logic [LEN_W-1:0]         post_len;
    logic [NUM_KW-1:0]        post_cand;
    logic [5:0]               post_ops;
    logic [POSITION_BITS-1:0] post_start;
    logic                     post_ovf;
    logic                     close_v;
    logic                     single_v;
    logic                     flush_v;
    tok_class_t               close_cls;
    tok_class_t               flush_cls;
    tok_beat_t                close_beat;
    tok_beat_t                second_beat;
    tok_beat_t                push0;
    tok_beat_t                push1;
    logic [1:0]               push_n;

    assign accept      = byte_valid && byte_ready;
    assign pop         = token_valid && token_ready;
    assign byte_ready  = count_reg <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH - 2);
    assign token_valid = count_reg != '0;
    assign opc         = op_char(char_code);

    // Does this byte continue the open token?
    always_comb
    begin
        case (mode_reg)
            MODE_IDENT: extend = is_letter(char_code) || is_digit(char_code);
            MODE_INT:   extend = is_digit(char_code);
            MODE_OPER:  extend = opc != OPC_NONE;
            default:    extend = 1'b0;
        endcase
    end

    // State after the byte: the open token grows, a new one opens, or the scanner goes idle.
    always_comb
    begin
        post_mode  = mode_reg;
        post_len   = open_len_reg;
        post_cand  = cand_reg;
        post_ops   = ops_reg;
        post_start = start_reg;
        post_ovf   = ovf_reg;
        single_v   = 1'b0;
        if (extend) begin
            if (mode_reg == MODE_IDENT) begin
                post_cand = kw_filter(cand_reg, open_len_reg, char_code);
            end
            if (mode_reg == MODE_OPER && open_len_reg == LEN_W'(0)) begin
                post_ops = {ops_reg[5:3], ops_reg[2:0] | opc};
            end
            else if (mode_reg == MODE_OPER && open_len_reg == LEN_W'(1)) begin
                post_ops = {ops_reg[5:3] | opc, ops_reg[2:0]};
            end
            if (open_len_reg < MAX_LEN) begin
                post_len = open_len_reg + LEN_W'(1);
            end
            else begin
                post_ovf = 1'b1;
            end
        end
        else begin
            post_len   = LEN_W'(1);
            post_cand  = KW_ALL;
            post_ops   = '0;
            post_ovf   = 1'b0;
            post_start = pos_reg;
            if (is_letter(char_code)) begin
                post_mode = MODE_IDENT;
                post_cand = kw_filter(KW_ALL, LEN_W'(0), char_code);
            end
            else if (is_digit(char_code)) begin
                post_mode = MODE_INT;
            end
            else if (opc != OPC_NONE) begin
                post_mode = MODE_OPER;
                post_ops  = {3'd0, opc};
            end
            else begin
                post_mode  = MODE_IDLE;
                post_len   = '0;
                post_start = start_reg;
                single_v   = !is_blank(char_code);
            end
        end
    end

    // Tokens caused by this byte, in order: the closed token, then a single or a flushed one.
    always_comb
    begin
        close_v   = !extend && mode_reg != MODE_IDLE;
        flush_v   = end_of_source && post_mode != MODE_IDLE;
        close_cls = classify(mode_reg, open_len_reg, cand_reg, ops_reg, ovf_reg);
        flush_cls = classify(post_mode, post_len, post_cand, post_ops, post_ovf);

        close_beat = '{kind: close_cls.kind, kw: close_cls.kw, op: close_cls.op,
                       start: TOKEN_START_W'(start_reg), len: open_len_reg,
                       ovf: ovf_reg, last: !(single_v || flush_v)};
        if (single_v) begin
            second_beat = '{kind: single_kind(char_code), kw: 3'd0, op: OP_ASSIGN,
                            start: TOKEN_START_W'(pos_reg), len: LEN_W'(1),
                            ovf: 1'b0, last: 1'b1};
        end
        else begin
            second_beat = '{kind: flush_cls.kind, kw: flush_cls.kw, op: flush_cls.op,
                            start: TOKEN_START_W'(post_start), len: post_len,
                            ovf: post_ovf, last: 1'b1};
        end

        push0  = close_v ? close_beat : second_beat;
        push1  = second_beat;
        push_n = 2'(close_v) + 2'(single_v || flush_v);
        if (!accept) begin
            push_n = 2'd0;
        end
    end

    // Next open-token state; end of source closes everything and rewinds the offset.
    always_comb
    begin
        mode_next     = mode_reg;
        open_len_next = open_len_reg;
        cand_next     = cand_reg;
        ops_next      = ops_reg;
        start_next    = start_reg;
        ovf_next      = ovf_reg;
        pos_next      = pos_reg;
        if (accept) begin
            start_next = post_start;
            if (end_of_source) begin
                mode_next     = MODE_IDLE;
                open_len_next = '0;
                cand_next     = KW_ALL;
                ops_next      = '0;
                ovf_next      = 1'b0;
                pos_next      = '0;
            end
            else begin
                mode_next     = post_mode;
                open_len_next = post_len;
                cand_next     = post_cand;
                ops_next      = post_ops;
                ovf_next      = post_ovf;
                pos_next      = pos_reg + POSITION_BITS'(1);
            end
        end
    end

    // Queue pointers and fill count.
    always_comb
    begin
        tail_next  = tail_reg + QUEUE_PTR_W'(push_n);
        head_next  = pop ? head_reg + QUEUE_PTR_W'(1) : head_reg;
        count_next = count_reg + (QUEUE_PTR_W + 1)'(push_n) - (QUEUE_PTR_W + 1)'(pop);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg     <= MODE_IDLE;
            open_len_reg <= '0;
            cand_reg     <= KW_ALL;
            ops_reg      <= '0;
            start_reg    <= '0;
            ovf_reg      <= 1'b0;
            pos_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
        end
        else begin
            mode_reg     <= mode_next;
            open_len_reg <= open_len_next;
            cand_reg     <= cand_next;
            ops_reg      <= ops_next;
            start_reg    <= start_next;
            ovf_reg      <= ovf_next;
            pos_reg      <= pos_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
        end
    end

    // Token queue storage.
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0) begin
            queue_reg[tail_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            queue_reg[tail_reg + QUEUE_PTR_W'(1)] <= push1;
        end
    end

    // Token beat fields from the head of the queue.
    assign token_kind      = queue_reg[head_reg].kind;
    assign keyword_index   = queue_reg[head_reg].kw;
    assign operator_code   = queue_reg[head_reg].op;
    assign token_start     = queue_reg[head_reg].start;
    assign token_length    = queue_reg[head_reg].len;
    assign length_overflow = queue_reg[head_reg].ovf;
    assign last_of_run     = queue_reg[head_reg].last;

    // The queue never holds more entries than it has.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH))
        else $error("token queue over-filled");

    // With no token open, no length or overflow is left behind.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_IDLE |-> open_len_reg == '0 && !ovf_reg)
        else $error("idle scanner holds token residue");

    // The open length saturates at the maximum and overflow only marks a full token.
    a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
        open_len_reg <= MAX_LEN && (!ovf_reg || open_len_reg == MAX_LEN))
        else $error("open token length out of range");

    // End of source rewinds the byte offset and leaves no token open.
    a_eos_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_source |=> pos_reg == '0 && mode_reg == MODE_IDLE)
        else $error("end of source did not rewind the scanner");

    // A byte beat never finds the queue without room for its tokens.
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> count_reg <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH))
        else $error("token queue overrun after byte beat");

endmodule
